// ----- rtl/core/sird_pkg.sv -----
// Shared types, character constants and the symbol lookup for the radix
// digit converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sird_pkg;

	localparam int DIGIT_W    = 4;
	localparam int MAX_DIGITS = 32;
	localparam int ADDR_W     = $clog2(MAX_DIGITS);
	localparam int COUNT_W    = ADDR_W + 1;
	localparam int VALUE_W    = 32;
	localparam int RADIX_W    = 5;
	localparam int CHAR_W     = 8;
	localparam int NUM_SYMS   = 16;
	localparam int SYM_IDX_W  = 4;

	localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;
	localparam logic [RADIX_W-1:0] MAX_RADIX = 5'd16;

	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

	localparam logic [RADIX_W-1:0] RADIX_RESET   = 5'd10;
	localparam logic [63:0]        SYM_LO_RESET  = 64'h3736353433323130;
	localparam logic [63:0]        SYM_HI_RESET  = 64'h4645444342413938;

	typedef enum logic [1:0] {
		REG_RADIX  = 2'd0,
		REG_SYM_LO = 2'd1,
		REG_SYM_HI = 2'd2
	} reg_index_t;

	// Symbol table, entry k is the character for digit value k.
	typedef logic [NUM_SYMS-1:0][CHAR_W-1:0] sym_tab_t;

	typedef struct packed {
		logic done;
		logic ok;
	} chk_status_t;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  addr;
		logic [DIGIT_W-1:0] digit;
		logic               done;
		logic [COUNT_W-1:0] count;
	} div_status_t;

	function automatic logic [CHAR_W-1:0] symbol_of(input sym_tab_t tab,
			input logic [DIGIT_W-1:0] d);
		return tab[d];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/signed_int_to_radix_digits_core.sv -----
// Top level of the signed integer to radix text converter: configuration
// registers, sequencer, digit stack and output register. Depends on
// sird_pkg, sird_alpha_chk and sird_divider.
`timescale 1ns / 1ps
`default_nettype none

// Converts one signed 32-bit value per input transfer into its text in the
// configured radix (2 to 16) with the configured alphabet. The output is a
// stream of 8-bit characters: a '-' for negative values, then the digit
// symbols most significant first, tlast on the final character. Zero gives
// the single symbol for digit value 0, and -2147483648 converts correctly.
// If the radix is outside 2..16, or a symbol in use repeats, is '+' or '-',
// or lies outside 32..126, the value is dropped and nothing is output.
// One item at a time: after the input transfer the alphabet check walks the
// symbols in use (stopping early when a bad symbol is found), the divider
// makes each digit from the whole magnitude at 4 dividend bits per cycle and
// then hands over the count, a '-' goes out first for a negative value, and
// after one stack read the digit characters leave at one per cycle while the output is not stalled.
// Configuration writes are taken at any time but belong to idle periods; the
// last character may still wait in the output register while the next value
// is accepted.
module signed_int_to_radix_digits_core
	import sird_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration write port
	input  wire logic         cfg_wr_en,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data,
	// input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [31:0]  s_tdata,   // [31:0] value (signed)
	// output stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [7:0]        m_tdata,   // [7:0] symbol
	output logic              m_tlast    // last_symbol
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CHECK  = 6'b000010,
		ST_DIVIDE = 6'b000100,
		ST_SIGN   = 6'b001000,
		ST_READ   = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t              state_q;
	logic [RADIX_W-1:0]  radix_q;
	logic [63:0]         sym_lo_q;
	logic [63:0]         sym_hi_q;
	logic [VALUE_W-1:0]  value_q;
	logic [COUNT_W-1:0]  cnt_q;

	logic [DIGIT_W-1:0]  stack_mem [MAX_DIGITS];
	logic [DIGIT_W-1:0]  rd_data_q;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;

	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_sym_q;
	logic                out_last_q;

	sym_tab_t            sym_tab;
	chk_status_t         chk_st;
	div_status_t         div_st;
	logic                in_xfer;
	logic                radix_ok;
	logic                chk_start;
	logic                div_start;
	logic [VALUE_W-1:0]  magnitude;
	logic                out_free;
	logic                negative;

	assign sym_tab   = {sym_hi_q, sym_lo_q};
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign radix_ok  = (radix_q >= MIN_RADIX) && (radix_q <= MAX_RADIX);
	assign chk_start = in_xfer && radix_ok;
	assign div_start = (state_q == ST_CHECK) && chk_st.done && chk_st.ok;
	assign negative  = value_q[VALUE_W-1];
	// widen-free negate: the 32-bit unsigned magnitude covers the most negative value
	assign magnitude = negative ? (VALUE_W'(0) - value_q) : value_q;
	assign out_free  = !out_valid_q || m_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= RADIX_RESET;
			sym_lo_q <= SYM_LO_RESET;
			sym_hi_q <= SYM_HI_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RADIX:  radix_q  <= cfg_data[RADIX_W-1:0];
				REG_SYM_LO: sym_lo_q <= cfg_data;
				REG_SYM_HI: sym_hi_q <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// Hold the accepted value for the whole conversion
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			value_q <= s_tdata;
		end
	end

	sird_alpha_chk u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (chk_start),
		.radix   (radix_q),
		.sym_tab (sym_tab),
		.status  (chk_st)
	);

	sird_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.magnitude (magnitude),
		.radix     (radix_q),
		.status    (div_st)
	);

	// Digit stack: written by the divider, read back top down
	always_ff @(posedge clk) begin
		if (div_st.we) begin
			stack_mem[div_st.addr] <= div_st.digit;
		end
		if (rd_en) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	always_comb begin
		rd_en = 1'b0;
		case (state_q)
			ST_READ: rd_en = 1'b1;
			ST_EMIT: rd_en = out_free && (cnt_q != '0);
			default: rd_en = 1'b0;
		endcase
	end

	assign rd_addr = ADDR_W'(cnt_q - COUNT_W'(1));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// a bad radix drops the value right here
					if (chk_start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (chk_st.done) begin
						state_q <= chk_st.ok ? ST_DIVIDE : ST_IDLE;
					end
				end
				ST_DIVIDE: begin
					if (div_st.done) begin
						cnt_q   <= div_st.count;
						state_q <= negative ? ST_SIGN : ST_READ;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					cnt_q   <= cnt_q - COUNT_W'(1);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (cnt_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q - COUNT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: advance whenever the slot is free and a character is ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_SIGN || state_q == ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_SIGN) begin
				out_sym_q  <= CH_MINUS;
				out_last_q <= 1'b0;
			end else if (state_q == ST_EMIT) begin
				out_sym_q  <= symbol_of(sym_tab, rd_data_q);
				out_last_q <= (cnt_q == '0);
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sym_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_div_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ST_DIVIDE))
		else $error("divider finished outside the divide phase");

	a_stack_write_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.we |-> (state_q == ST_DIVIDE))
		else $error("digit stack written outside the divide phase");

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (cnt_q != '0))
		else $error("digit stack read with no digits left");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && out_free && (cnt_q == '0)) |=> (state_q == ST_IDLE) && m_tlast)
		else $error("final character not marked or item not closed");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/sird_alpha_chk.sv -----
// Alphabet checker: walks the symbols in use one per cycle and flags
// repeats, sign characters and non-printable codes. Depends on sird_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sird_alpha_chk
	import sird_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [RADIX_W-1:0] radix,
	input  wire sym_tab_t           sym_tab,
	output chk_status_t             status
);

	logic                 busy_q;
	logic                 done_q;
	logic                 ok_q;
	logic [SYM_IDX_W-1:0] idx_q;
	logic [CHAR_W-1:0]    cur;
	logic                 bad;
	logic                 at_end;

	always_comb begin
		cur = sym_tab[idx_q];
		bad = (cur < CH_SPACE) || (cur >= CH_DEL) || (cur == CH_PLUS) || (cur == CH_MINUS);
		for (int j = 0; j < NUM_SYMS; j++) begin
			if ((SYM_IDX_W'(j) > idx_q) && (RADIX_W'(j) < radix) && (sym_tab[j] == cur)) begin
				bad = 1'b1;
			end
		end
		at_end = ({1'b0, idx_q} == (radix - RADIX_W'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ok_q   <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ok_q   <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				// drop out early on the first bad symbol
				if (bad || at_end) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					ok_q   <= ~bad;
				end else begin
					idx_q <= idx_q + SYM_IDX_W'(1);
				end
			end
		end
	end

	assign status.done = done_q;
	assign status.ok   = ok_q;

endmodule

`default_nettype wire

// ----- rtl/core/sird_divider.sv -----
// Repeated division by the radix, four dividend bits per cycle, producing
// digit values least significant first. Depends on sird_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sird_divider
	import sird_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [VALUE_W-1:0] magnitude,
	input  wire logic [RADIX_W-1:0] radix,
	output div_status_t             status
);

	localparam int NIB_STEPS = VALUE_W / DIGIT_W;
	localparam int NIB_W     = $clog2(NIB_STEPS);

	logic                 busy_q;
	logic                 done_q;
	logic [VALUE_W-1:0]   mag_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [NIB_W-1:0]     nib_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic [RADIX_W-1:0]   radix_q;

	logic [RADIX_W-1:0]   part;
	logic [DIGIT_W-1:0]   rem_d;
	logic [DIGIT_W-1:0]   qnib;
	logic [VALUE_W-1:0]   quot;
	logic                 pass_end;
	logic [COUNT_W-1:0]   cnt_inc;

	// Four restoring steps on the top nibble; remainder stays below radix.
	always_comb begin
		rem_d = rem_q;
		qnib  = '0;
		for (int b = DIGIT_W - 1; b >= 0; b--) begin
			part = {rem_d, mag_q[VALUE_W - DIGIT_W + b]};
			if (part >= radix_q) begin
				part    = part - radix_q;
				qnib[b] = 1'b1;
			end
			rem_d = part[DIGIT_W-1:0];
		end
		quot     = {mag_q[VALUE_W-DIGIT_W-1:0], qnib};
		pass_end = busy_q && (nib_q == NIB_W'(NIB_STEPS - 1));
		cnt_inc  = cnt_q + COUNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			nib_q   <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				nib_q  <= '0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				nib_q <= nib_q + NIB_W'(1);
				if (pass_end) begin
					cnt_q <= cnt_inc;
					if ((quot == '0) || (cnt_inc == COUNT_W'(MAX_DIGITS))) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q   <= magnitude;
			rem_q   <= '0;
			radix_q <= radix;
		end else if (busy_q) begin
			mag_q <= quot;
			rem_q <= pass_end ? '0 : rem_d;
		end
	end

	assign status.we    = pass_end;
	assign status.addr  = cnt_q[ADDR_W-1:0];
	assign status.digit = rem_d;
	assign status.done  = done_q;
	assign status.count = cnt_q;

endmodule

`default_nettype wire
